// ----- rtl/occs_pkg.sv -----
`default_nettype none

package occs_pkg;

  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 1;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_CODE_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_OVERSAMPLE  = 1'b1;

  // Item modes.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_EMIT   = 2'd1;
  localparam logic [1:0] MODE_REWIND = 2'd2;

  localparam logic [3:0] MAX_OVERSAMPLE = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] chip_index;
    logic       chip_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       buffer_end;
  } out_item_t;

  // Control from the sequencer to the position counter.
  typedef struct packed {
    logic step;
    logic rewind;
  } pos_ctrl_t;

  // Control from the sequencer to the byte packer.
  typedef struct packed {
    logic shift;
    logic load;
  } pack_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/occs_ram.sv -----
`default_nettype none

module occs_ram #(
  parameter int Width = 1,
  parameter int Depth = 512,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/occs_pos.sv -----
`default_nettype none

module occs_pos
  import occs_pkg::*;
#(
  parameter int MaxChips = 512,
  localparam int PosW = $clog2(MaxChips),
  localparam int LenW = ($clog2(MaxChips + 1) > CfgDataW) ? $clog2(MaxChips + 1) : CfgDataW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pos_ctrl_t       ctrl_i,
  input  wire logic [9:0]      code_length_i,
  input  wire logic [3:0]      oversample_i,
  output logic      [PosW-1:0] chip_pos_o,
  output logic                 at_start_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      rep_q, rep_d;
  logic [LenW-1:0] len_eff, pos_inc;
  logic [3:0]      osf_eff, rep_inc;

  always_comb begin
    if (code_length_i == 10'd0) begin
      len_eff = LenW'(1);
    end else if (LenW'(code_length_i) > LenW'(MaxChips)) begin
      len_eff = LenW'(MaxChips);
    end else begin
      len_eff = LenW'(code_length_i);
    end

    if (oversample_i == 4'd0) begin
      osf_eff = 4'd1;
    end else if (oversample_i > MAX_OVERSAMPLE) begin
      osf_eff = MAX_OVERSAMPLE;
    end else begin
      osf_eff = oversample_i;
    end
  end

  // A repeat count left at or above a lowered oversample ends its chip on the next bit,
  // and a position left beyond a shortened code wraps to chip zero when it next advances.
  always_comb begin
    rep_inc = {1'b0, rep_q} + 4'd1;
    pos_inc = LenW'(pos_q) + LenW'(1);
    pos_d   = pos_q;
    rep_d   = rep_q;
    if (ctrl_i.rewind) begin
      pos_d = '0;
      rep_d = '0;
    end else if (ctrl_i.step) begin
      if (rep_inc >= osf_eff) begin
        rep_d = '0;
        pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
      end else begin
        rep_d = rep_inc[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rep_q <= '0;
    end else begin
      pos_q <= pos_d;
      rep_q <= rep_d;
    end
  end

  assign chip_pos_o = pos_q;
  assign at_start_o = (pos_q == '0) && (rep_q == '0);

endmodule

`default_nettype wire

// ----- rtl/occs_pack.sv -----
`default_nettype none

module occs_pack
  import occs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pack_ctrl_t ctrl_i,
  input  wire logic       bit_i,
  input  wire logic       buffer_end_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output out_item_t       out_item_o
);

  logic [7:0] shift_q, shift_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  // The earliest stream bit ends up in the MSB after eight shifts.
  always_comb begin
    shift_d     = ctrl_i.shift ? {shift_q[6:0], bit_i} : shift_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.load) begin
      out_d.out_byte   = shift_q;
      out_d.buffer_end = buffer_end_i;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/oversampled_chip_code_serializer.sv -----
// Load and rewind items are taken one per cycle while idle and return nothing.
// An emit item reads the code store one chip per cycle, eight reads in all, then
// passes the last-bit and hold states; its byte is loaded into the output register once
// the output slot is free, and no next item is taken until then.
// After reset the code store is cleared one chip per cycle, all MAX_CHIPS chips, with no
// item accepted meanwhile; registers reset to code length 1 and oversample 1.
`default_nettype none

module oversampled_chip_code_serializer
  import occs_pkg::*;
#(
  parameter int MAX_CHIPS = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_item_o
);

  localparam int PosW = $clog2(MAX_CHIPS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [2:0]      bit_cnt_q, bit_cnt_d;
  logic [PosW-1:0] clr_cnt_q, clr_cnt_d;
  logic [9:0]      code_length_q;
  logic [3:0]      oversample_q;

  logic            in_fire, slot_free;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [PosW-1:0] ram_waddr, chip_pos;
  logic            at_start;
  pos_ctrl_t       pos_ctrl;
  pack_ctrl_t      pack_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= 10'd1;
      oversample_q  <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE_LENGTH: code_length_q <= cfg_wdata_i;
        CFG_OVERSAMPLE:  oversample_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d          = state_q;
    bit_cnt_d        = bit_cnt_q;
    clr_cnt_d        = clr_cnt_q;
    ram_we           = 1'b0;
    ram_waddr        = PosW'(in_item_i.chip_index);
    ram_wdata        = in_item_i.chip_value;
    pos_ctrl         = '0;
    pack_ctrl        = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = 1'b0;
        clr_cnt_d = clr_cnt_q + PosW'(1);
        if (clr_cnt_q == PosW'(MAX_CHIPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.mode)
            MODE_LOAD:   ram_we = (int'(in_item_i.chip_index) < MAX_CHIPS);
            MODE_REWIND: pos_ctrl.rewind = 1'b1;
            MODE_EMIT: begin
              bit_cnt_d = 3'd0;
              state_d   = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // The read of this chip returns next cycle, so each bit is shifted in while the following chip is read.
        pos_ctrl.step   = 1'b1;
        pack_ctrl.shift = (bit_cnt_q != 3'd0);
        bit_cnt_d       = bit_cnt_q + 3'd1;
        if (bit_cnt_q == 3'd7) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        pack_ctrl.shift = 1'b1;
        state_d         = ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) begin
          pack_ctrl.load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      bit_cnt_q <= '0;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  occs_ram #(
    .Width(1),
    .Depth(MAX_CHIPS)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(chip_pos),
    .rdata_o(ram_rdata)
  );

  occs_pos #(
    .MaxChips(MAX_CHIPS)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (pos_ctrl),
    .code_length_i(code_length_q),
    .oversample_i (oversample_q),
    .chip_pos_o   (chip_pos),
    .at_start_o   (at_start)
  );

  occs_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (pack_ctrl),
    .bit_i       (ram_rdata),
    .buffer_end_i(at_start),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // The last bit of a byte arrives only after all eight chip reads were issued.
  a_last_after_eight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST |-> $past(state_q) == ST_RUN && $past(bit_cnt_q) == 3'd7)
    else $error("byte completed before eight reads");

  // The stream position moves only while a byte is being read or on a rewind.
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD || state_q == ST_LAST || (state_q == ST_IDLE && !in_fire))
      |=> $stable(chip_pos))
    else $error("stream position moved outside an emit");

  // A fresh result only appears when a finished byte is handed over.
  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_HOLD)
    else $error("result shown without a finished byte");

endmodule

`default_nettype wire
